// ===== rtl/core/gcks_pkg.sv =====
package gcks_pkg;

  localparam int MAX_KNOTS = 256;

  localparam int CMD_W     = 2;
  localparam int KIDX_W    = 8;
  localparam int VAL_W     = 63;
  localparam int CNT_W     = 9;
  localparam int CELL_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam int ADDR_W    = $clog2(MAX_KNOTS);
  localparam int STEPS     = ADDR_W;
  localparam int LAST_STEP = 2 * STEPS;
  localparam int STEP_W    = $clog2(LAST_STEP + 1);

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_X  = 2'd0,
    CMD_WR_Q2 = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_KNOT_COUNT  = 2'd0,
    CFG_Q2_KNOT_COUNT = 2'd1,
    CFG_UNUSED_2      = 2'd2,
    CFG_UNUSED_3      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FLUSH
  } state_t;

  // Upper search bound: the knot count held to its legal range, less one.
  function automatic logic [ADDR_W-1:0] clamp_hi(input logic [CNT_W-1:0] cnt);
    int c;
    c = int'(cnt);
    if (c < 2) begin
      c = 2;
    end else if (c > MAX_KNOTS) begin
      c = MAX_KNOTS;
    end
    return ADDR_W'(c - 1);
  endfunction

endpackage

// ===== rtl/core/gcks_ram.sv =====
module gcks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/grid_cell_knot_search_top.sv =====
// A knot write leaves the block idle, so it is ready again on the next cycle.
// A query runs a bisection search on one shared comparator, alternating between the axes
// behind the registered knot memory read, then ST_FLUSH loads the result register; no new
// input is taken until the block is back in idle.
// A result held back by out_ready stalls the next query in ST_FLUSH until it is taken.
// Synchronous reset clears control and sets both counts to 2; knot memories start undefined.
module grid_cell_knot_search_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gcks_pkg::CMD_W-1:0]     in_command,
  input  logic [gcks_pkg::KIDX_W-1:0]    in_knot_index,
  input  logic [gcks_pkg::VAL_W-1:0]     in_knot_value,
  input  logic [gcks_pkg::VAL_W-1:0]     in_query_x,
  input  logic [gcks_pkg::VAL_W-1:0]     in_query_q2,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gcks_pkg::CELL_W-1:0]    out_x_cell,
  output logic [gcks_pkg::CELL_W-1:0]    out_q2_cell,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gcks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcks_pkg::CNT_W-1:0]     cfg_data
);

  import gcks_pkg::*;

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  x_count_r, x_count_nxt;
  logic [CNT_W-1:0]  q2_count_r, q2_count_nxt;
  logic [VAL_W-1:0]  x_val_r, x_val_nxt;
  logic [VAL_W-1:0]  q2_val_r, q2_val_nxt;
  logic [ADDR_W-1:0] x_lo_r, x_lo_nxt, x_hi_r, x_hi_nxt;
  logic [ADDR_W-1:0] q2_lo_r, q2_lo_nxt, q2_hi_r, q2_hi_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] out_x_cell_r, out_x_cell_nxt;
  logic [CELL_W-1:0] out_q2_cell_r, out_q2_cell_nxt;

  cmd_t              cmd;
  logic              in_xfer, query_acc, idx_ok, x_we, q2_we;
  logic [ADDR_W-1:0] knot_addr, x_mid, q2_mid;
  logic [VAL_W-1:0]  x_rdata, q2_rdata, cmp_val, cmp_knot;
  logic              cmp_en, cmp_q2, cmp_gt, x_open, q2_open, out_load;

  assign cmd       = cmd_t'(in_command);
  assign in_xfer   = in_valid && in_ready;
  assign query_acc = in_xfer && (cmd == CMD_QUERY);
  assign idx_ok    = int'(in_knot_index) < MAX_KNOTS;
  assign knot_addr = ADDR_W'(in_knot_index);
  assign x_we      = in_xfer && (cmd == CMD_WR_X) && idx_ok;
  assign q2_we     = in_xfer && (cmd == CMD_WR_Q2) && idx_ok;

  assign x_mid  = x_lo_r + ((x_hi_r - x_lo_r) >> 1);
  assign q2_mid = q2_lo_r + ((q2_hi_r - q2_lo_r) >> 1);

  gcks_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KNOTS)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (knot_addr),
    .wdata (in_knot_value),
    .raddr (x_mid),
    .rdata (x_rdata)
  );

  gcks_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KNOTS)) u_q2_ram (
    .clk   (clk),
    .we    (q2_we),
    .waddr (knot_addr),
    .wdata (in_knot_value),
    .raddr (q2_mid),
    .rdata (q2_rdata)
  );

  // The x axis is compared on odd steps and the Q2 axis on even steps past zero, each
  // against the knot read for it on the step before.
  assign cmp_en   = (state_r == ST_SEARCH) && (step_r != '0);
  assign cmp_q2   = ~step_r[0];
  assign cmp_val  = cmp_q2 ? q2_val_r : x_val_r;
  assign cmp_knot = cmp_q2 ? q2_rdata : x_rdata;
  assign cmp_gt   = cmp_val > cmp_knot;
  assign x_open   = (x_hi_r - x_lo_r) > ADDR_W'(1);
  assign q2_open  = (q2_hi_r - q2_lo_r) > ADDR_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (step_r == STEP_W'(LAST_STEP)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SEARCH: in_ready = 1'b0;
      ST_FLUSH:  out_load = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    step_nxt   = (state_r == ST_SEARCH) ? step_r + STEP_W'(1) : '0;
    x_val_nxt  = x_val_r;
    q2_val_nxt = q2_val_r;
    x_lo_nxt   = x_lo_r;
    x_hi_nxt   = x_hi_r;
    q2_lo_nxt  = q2_lo_r;
    q2_hi_nxt  = q2_hi_r;
    if (query_acc) begin
      x_val_nxt  = in_query_x;
      q2_val_nxt = in_query_q2;
      x_lo_nxt   = '0;
      x_hi_nxt   = clamp_hi(x_count_r);
      q2_lo_nxt  = '0;
      q2_hi_nxt  = clamp_hi(q2_count_r);
    end else if (cmp_en && !cmp_q2 && x_open) begin
      if (cmp_gt) begin
        x_lo_nxt = x_mid;
      end else begin
        x_hi_nxt = x_mid;
      end
    end else if (cmp_en && cmp_q2 && q2_open) begin
      if (cmp_gt) begin
        q2_lo_nxt = q2_mid;
      end else begin
        q2_hi_nxt = q2_mid;
      end
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_x_cell_nxt  = out_x_cell_r;
    out_q2_cell_nxt = out_q2_cell_r;
    if (out_load) begin
      out_valid_nxt   = 1'b1;
      out_x_cell_nxt  = CELL_W'(x_lo_r);
      out_q2_cell_nxt = CELL_W'(q2_lo_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    x_count_nxt  = x_count_r;
    q2_count_nxt = q2_count_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_KNOT_COUNT:  x_count_nxt  = cfg_data;
        CFG_Q2_KNOT_COUNT: q2_count_nxt = cfg_data;
        default: begin
          x_count_nxt  = x_count_r;
          q2_count_nxt = q2_count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      x_count_r   <= CNT_RESET;
      q2_count_r  <= CNT_RESET;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      x_count_r   <= x_count_nxt;
      q2_count_r  <= q2_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_val_r       <= x_val_nxt;
    q2_val_r      <= q2_val_nxt;
    x_lo_r        <= x_lo_nxt;
    x_hi_r        <= x_hi_nxt;
    q2_lo_r       <= q2_lo_nxt;
    q2_hi_r       <= q2_hi_nxt;
    out_x_cell_r  <= out_x_cell_nxt;
    out_q2_cell_r <= out_q2_cell_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_x_cell  = out_x_cell_r;
  assign out_q2_cell = out_q2_cell_r;

endmodule

// ===== rtl/core/gcks_checker.sv =====
module gcks_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [gcks_pkg::CMD_W-1:0]  in_command,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gcks_pkg::CELL_W-1:0] out_x_cell,
  input logic [gcks_pkg::CELL_W-1:0] out_q2_cell
);

  import gcks_pkg::*;

  localparam logic [CELL_W-1:0] CELL_MAX = CELL_W'(MAX_KNOTS - 2);

  logic query_xfer, other_xfer;

  assign query_xfer = in_valid && in_ready && (cmd_t'(in_command) == CMD_QUERY);
  assign other_xfer = in_valid && in_ready && (cmd_t'(in_command) != CMD_QUERY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_x_cell) && $stable(out_q2_cell))
    else $error("Result changed while its transfer was stalled.");

  a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    query_xfer |=> !in_ready)
    else $error("Input ready directly after a query transfer.");

  a_write_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    other_xfer |=> in_ready)
    else $error("Input not ready after a knot write transfer.");

  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_cell <= CELL_MAX) && (out_q2_cell <= CELL_MAX))
    else $error("Cell index beyond the last cell.");

endmodule

bind grid_cell_knot_search_top gcks_checker u_gcks_checker (.*);

// ===== tb/grid_cell_knot_search_top_tb.sv =====
module grid_cell_knot_search_top_tb;
  import gcks_pkg::*;

  localparam int LIMIT    = 1000000;
  localparam int SETTLE   = 40;
  localparam int SHOW_MAX = 100;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] D_ONE   = 63'h3FF0_0000_0000_0000;
  localparam logic [VAL_W-1:0] D_TWO   = 63'h4000_0000_0000_0000;
  localparam logic [VAL_W-1:0] D_TEN   = 63'h4024_0000_0000_0000;
  localparam logic [VAL_W-1:0] D_HUND  = 63'h4059_0000_0000_0000;

  typedef struct packed {
    cmd_t              command;
    logic [KIDX_W-1:0] knot_index;
    logic [VAL_W-1:0]  knot_value;
    logic [VAL_W-1:0]  query_x;
    logic [VAL_W-1:0]  query_q2;
  } knot_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] x_cell;
    logic [CELL_W-1:0] q2_cell;
  } cell_pair_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = CMD_NOP;
  logic [KIDX_W-1:0]    in_knot_index = '0;
  logic [VAL_W-1:0]     in_knot_value = '0;
  logic [VAL_W-1:0]     in_query_x = '0;
  logic [VAL_W-1:0]     in_query_q2 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CELL_W-1:0]    out_x_cell;
  logic [CELL_W-1:0]    out_q2_cell;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_X_KNOT_COUNT;
  logic [CNT_W-1:0]     cfg_data = '0;

  knot_item_t       pend_items[$];
  cell_pair_t       cells_due[$];
  logic [VAL_W-1:0] x_store[MAX_KNOTS];
  logic [VAL_W-1:0] q2_store[MAX_KNOTS];
  logic [VAL_W-1:0] gen_x[MAX_KNOTS];
  logic [VAL_W-1:0] gen_q2[MAX_KNOTS];
  logic [CNT_W-1:0] x_count = CNT_RESET;
  logic [CNT_W-1:0] q2_count = CNT_RESET;
  int               cycles = 0;
  int               mismatches = 0;
  int               in_gap = 0;
  int               out_stall = 0;
  bit               in_xfer = 1'b0;
  bit               out_xfer = 1'b0;
  bit               idle_en = 1'b0;

  grid_cell_knot_search_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_knot_index (in_knot_index),
    .in_knot_value (in_knot_value),
    .in_query_x    (in_query_x),
    .in_query_q2   (in_query_q2),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x_cell    (out_x_cell),
    .out_q2_cell   (out_q2_cell),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] rand_val();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[VAL_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int usable_count(logic [CNT_W-1:0] c);
    int n;
    n = int'(c);
    if (n < 2) n = 2;
    if (n > MAX_KNOTS) n = MAX_KNOTS;
    return n;
  endfunction

  // Lower knot of the cell holding v, bisecting the copy of the table.
  function automatic logic [CELL_W-1:0] find_cell(logic [VAL_W-1:0] v, bit on_q2);
    int lo;
    int hi;
    int mid;
    logic [VAL_W-1:0] knot;
    lo = 0;
    hi = usable_count(on_q2 ? q2_count : x_count) - 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      knot = on_q2 ? q2_store[mid] : x_store[mid];
      if (v > knot) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return CELL_W'(lo);
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < SHOW_MAX) $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  always @(negedge clk) begin : driver
    knot_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_xfer) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pend_items.size() != 0) begin
        it = pend_items.pop_front();
        in_valid <= 1'b1;
        in_command <= it.command;
        in_knot_index <= it.knot_index;
        in_knot_value <= it.knot_value;
        in_query_x <= it.query_x;
        in_query_q2 <= it.query_q2;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    int g;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (out_xfer || $urandom_range(0, 7) == 0) begin
      g = pick_gap();
      out_ready <= (g == 0);
      out_stall <= (g > 0) ? g - 1 : 0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    cell_pair_t due;
    in_xfer <= in_valid && in_ready;
    out_xfer <= out_valid && out_ready;
    if (!rst_n) begin
      x_count = CNT_RESET;
      q2_count = CNT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_X_KNOT_COUNT) begin
          x_count = cfg_data;
        end else if (cfg_index == CFG_Q2_KNOT_COUNT) begin
          q2_count = cfg_data;
        end
      end
      if (out_valid && out_ready) begin
        if (cells_due.size() == 0) begin
          report_mismatch($sformatf("result x_cell %0d q2_cell %0d with none expected",
                                    out_x_cell, out_q2_cell));
        end else begin
          due = cells_due.pop_front();
          if (out_x_cell !== due.x_cell) begin
            report_mismatch($sformatf("x_cell %0d, expected %0d", out_x_cell, due.x_cell));
          end
          if (out_q2_cell !== due.q2_cell) begin
            report_mismatch($sformatf("q2_cell %0d, expected %0d", out_q2_cell, due.q2_cell));
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_command)
          CMD_WR_X: begin
            x_store[in_knot_index] = in_knot_value;
          end
          CMD_WR_Q2: begin
            q2_store[in_knot_index] = in_knot_value;
          end
          CMD_QUERY: begin
            due.x_cell = find_cell(in_query_x, 1'b0);
            due.q2_cell = find_cell(in_query_q2, 1'b1);
            cells_due.insert(cells_due.size(), due);
          end
          default: begin
          end
        endcase
      end
    end
  end

  task automatic push_item(cmd_t c, logic [KIDX_W-1:0] idx, logic [VAL_W-1:0] kv,
                           logic [VAL_W-1:0] qx, logic [VAL_W-1:0] qq);
    knot_item_t it;
    it.command = c;
    it.knot_index = idx;
    it.knot_value = kv;
    it.query_x = qx;
    it.query_q2 = qq;
    pend_items.insert(pend_items.size(), it);
  endtask

  task automatic push_write(bit on_q2, logic [KIDX_W-1:0] idx, logic [VAL_W-1:0] kv);
    if (on_q2) begin
      gen_q2[idx] = kv;
      push_item(CMD_WR_Q2, idx, kv, rand_val(), rand_val());
    end else begin
      gen_x[idx] = kv;
      push_item(CMD_WR_X, idx, kv, rand_val(), rand_val());
    end
  endtask

  task automatic push_query(logic [VAL_W-1:0] qx, logic [VAL_W-1:0] qq);
    push_item(CMD_QUERY, KIDX_W'($urandom_range(0, 255)), rand_val(), qx, qq);
  endtask

  // Sorted tables are built by rising steps that cannot pass the top value;
  // the narrow-step form packs knots closely so neighbouring values get hit.
  task automatic fill_table(bit on_q2, int n, bit sorted);
    logic [63:0] v;
    logic [63:0] span;
    logic [63:0] r;
    int i;
    v = ($urandom_range(0, 3) == 0) ? 64'd0 : ({1'b0, rand_val()} >> $urandom_range(1, 20));
    if ($urandom_range(0, 2) == 0) begin
      span = 64'($urandom_range(1, 4));
    end else begin
      span = ({1'b0, VAL_MAX} - v) / 64'(n);
    end
    for (i = 0; i < n; i++) begin
      if (!sorted) v = {1'b0, rand_val()};
      push_write(on_q2, KIDX_W'(i), v[VAL_W-1:0]);
      if (sorted && $urandom_range(0, 9) != 0) begin
        r = {$urandom, $urandom};
        v = v + r % (span + 64'd1);
      end
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_query(bit on_q2, int n);
    int k;
    logic [VAL_W-1:0] kv;
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] last;
    logic [VAL_W-1:0] q;
    logic [63:0] r;
    logic [63:0] width;
    k = $urandom_range(0, n - 1);
    kv = on_q2 ? gen_q2[k] : gen_x[k];
    first = on_q2 ? gen_q2[0] : gen_x[0];
    last = on_q2 ? gen_q2[n-1] : gen_x[n-1];
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1: q = kv;
      2: q = (kv == VAL_MAX) ? kv : kv + 63'd1;
      3: q = (kv == '0) ? kv : kv - 63'd1;
      4: q = '0;
      5: q = VAL_MAX;
      6: begin
        if (last > first) begin
          width = {1'b0, last} - {1'b0, first} + 64'd1;
          r = {1'b0, first} + r % width;
        end
        q = r[VAL_W-1:0];
      end
      default: q = r[VAL_W-1:0];
    endcase
    return q;
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return CNT_W'(r);
    if (r < 9) return CNT_W'($urandom_range(4, 24));
    return CNT_W'($urandom_range(25, 64));
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CNT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pend_items.size() != 0 || in_valid || cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(logic [CNT_W-1:0] xreg, logic [CNT_W-1:0] qreg, bit reload,
                           int queries);
    int nx;
    int nq;
    int i;
    int r;
    bit sorted;
    drain();
    write_reg(CFG_X_KNOT_COUNT, xreg);
    write_reg(CFG_Q2_KNOT_COUNT, qreg);
    idle_en = ($urandom_range(0, 3) != 0);
    nx = usable_count(xreg);
    nq = usable_count(qreg);
    sorted = ($urandom_range(0, 7) != 0);
    if (reload) begin
      fill_table(1'b0, nx, sorted);
      fill_table(1'b1, nq, sorted);
    end
    for (i = 0; i < queries; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        push_item(CMD_NOP, KIDX_W'($urandom_range(0, 255)), rand_val(), rand_val(),
                  rand_val());
      end else if (r == 1) begin
        push_write($urandom_range(0, 1) == 1, KIDX_W'($urandom_range(0, 255)), rand_val());
      end else begin
        push_query(pick_query(1'b0, nx), pick_query(1'b1, nq));
      end
    end
  endtask

  initial begin : stimulus
    int p;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // At the reset counts every query lands in cell zero.
    push_write(1'b0, 8'd0, '0);
    push_write(1'b0, 8'd1, VAL_MAX);
    push_write(1'b1, 8'd0, D_ONE);
    push_write(1'b1, 8'd1, D_HUND);
    push_query('0, '0);
    push_query(VAL_MAX, VAL_MAX);
    push_item(CMD_NOP, 8'd255, VAL_MAX, VAL_MAX, VAL_MAX);
    drain();

    write_reg(CFG_X_KNOT_COUNT, 9'd4);
    write_reg(CFG_Q2_KNOT_COUNT, 9'd3);
    push_write(1'b0, 8'd0, '0);
    push_write(1'b0, 8'd1, D_ONE);
    push_write(1'b0, 8'd2, D_TWO);
    push_write(1'b0, 8'd3, VAL_MAX);
    push_write(1'b1, 8'd0, D_ONE);
    push_write(1'b1, 8'd1, D_TEN);
    push_write(1'b1, 8'd2, D_HUND);
    push_write(1'b0, 8'd255, rand_val());
    push_write(1'b1, 8'd255, rand_val());
    push_query('0, '0);
    push_query(D_ONE, D_ONE);
    push_query(D_ONE + 63'd1, D_TEN);
    push_query(D_TWO, D_TEN + 63'd1);
    push_query(D_TWO + 63'd1, D_HUND);
    push_query(VAL_MAX, VAL_MAX);
    push_query(VAL_MAX - 63'd1, D_ONE - 63'd1);

    run_phase(9'd256, 9'd511, 1'b1, 80);
    run_phase(9'd511, 9'd0, 1'b0, 30);
    drain();
    write_reg(CFG_UNUSED_2, CNT_W'($urandom_range(0, 511)));
    write_reg(CFG_UNUSED_3, CNT_W'($urandom_range(0, 511)));
    run_phase(9'd257, 9'd1, 1'b0, 30);
    for (p = 0; p < 10; p++) begin
      run_phase(pick_count(), pick_count(), 1'b1, 35);
    end
    drain();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gcks_pkg.sv
rtl/core/gcks_ram.sv
rtl/core/grid_cell_knot_search_top.sv
rtl/core/gcks_checker.sv
tb/grid_cell_knot_search_top_tb.sv
